### rtl/sld_pkg.sv
// Shared types and constants of the sync-word, length-prefixed deframer.
// Holds the result record and the event and register codes; no dependencies.
`default_nettype none

package sld_pkg;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_SYNC_ERR = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR  = 2'd2;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'd148;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'd195;
    localparam logic [15:0] MAX_LENGTH_RESET  = 16'd512;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] flen;
    } t_result;

endpackage

`default_nettype wire

### rtl/sld_front.sv
// Front end: configuration registers and the header/payload state machine.
// Classifies each accepted byte and emits at most one result record. Uses sld_pkg.
`default_nettype none

module sld_front
    import sld_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    output t_result            o_result,
    output logic               o_result_valid
);

    localparam logic [1:0] HDR_SYNC1  = 2'd0;
    localparam logic [1:0] HDR_SYNC2  = 2'd1;
    localparam logic [1:0] HDR_LEN_HI = 2'd2;
    localparam logic [1:0] HDR_LEN_LO = 2'd3;

    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    logic [15:0] r_max_length;

    logic [1:0]  r_header_count, n_header_count;
    logic        r_in_payload, n_in_payload;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_expected, n_expected;
    logic [15:0] r_received, n_received;

    logic [15:0] w_count_inc;
    logic [15:0] w_length;

    assign w_count_inc = r_received + 16'd1;
    assign w_length    = {r_length_high, i_byte};

    always_comb begin
        n_header_count = r_header_count;
        n_in_payload   = r_in_payload;
        n_length_high  = r_length_high;
        n_expected     = r_expected;
        n_received     = r_received;
        o_result_valid = 1'b0;
        o_result.kind  = KIND_PAYLOAD;
        o_result.data  = i_byte;
        o_result.last  = 1'b0;
        o_result.flen  = 16'd0;
        if (i_accept) begin
            if (r_in_payload) begin
                o_result_valid = 1'b1;
                o_result.flen  = r_expected;
                n_received     = w_count_inc;
                if (w_count_inc >= r_expected) begin
                    o_result.last = 1'b1;
                    n_in_payload  = 1'b0;
                    n_received    = 16'd0;
                    n_expected    = 16'd0;
                end
            end else begin
                case (r_header_count)
                    HDR_SYNC1: begin
                        if (i_byte == r_sync_first) begin
                            n_header_count = HDR_SYNC2;
                        end else begin
                            o_result_valid = 1'b1;
                            o_result.kind  = KIND_SYNC_ERR;
                        end
                    end
                    HDR_SYNC2: begin
                        if (i_byte == r_sync_second) begin
                            n_header_count = HDR_LEN_HI;
                        end else begin
                            n_header_count = (i_byte == r_sync_first) ? HDR_SYNC2 : HDR_SYNC1;
                            o_result_valid = 1'b1;
                            o_result.kind  = KIND_SYNC_ERR;
                        end
                    end
                    HDR_LEN_HI: begin
                        n_length_high  = i_byte;
                        n_header_count = HDR_LEN_LO;
                    end
                    default: begin
                        n_expected     = w_length;
                        n_header_count = HDR_SYNC1;
                        n_received     = 16'd0;
                        if (w_length == 16'd0 || w_length > r_max_length) begin
                            o_result_valid = 1'b1;
                            o_result.kind  = KIND_LEN_ERR;
                            o_result.flen  = w_length;
                        end else begin
                            n_in_payload = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first   <= SYNC_FIRST_RESET;
            r_sync_second  <= SYNC_SECOND_RESET;
            r_max_length   <= MAX_LENGTH_RESET;
            r_header_count <= HDR_SYNC1;
            r_in_payload   <= 1'b0;
            r_length_high  <= 8'd0;
            r_expected     <= 16'd0;
            r_received     <= 16'd0;
        end else begin
            r_header_count <= n_header_count;
            r_in_payload   <= n_in_payload;
            r_length_high  <= n_length_high;
            r_expected     <= n_expected;
            r_received     <= n_received;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                    REG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                    REG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sld_queue.sv
// Two-entry queue of result records between the front end and the output stage.
// Uses the record type from sld_pkg.
`default_nettype none

module sld_queue
    import sld_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_result      i_data,
    input  wire logic    i_pop,
    output t_result      o_data,
    output logic         o_valid,
    output logic         o_full
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/sld_back.sv
// Output stage: pulls records from the queue into a register that drives the
// result channel and holds it while the receiver stalls. Uses sld_pkg.
`default_nettype none

module sld_back
    import sld_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  t_result      i_data,
    input  wire logic    i_valid,
    output logic         o_pop,
    output t_result      o_result,
    output logic         o_valid,
    input  wire logic    i_ready
);

    logic    r_valid;
    t_result r_result;

    assign o_pop    = i_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/sync_length_stream_deframer.sv
// Top level of the sync-word, length-prefixed byte stream deframer.
// Instantiates sld_front, sld_queue and sld_back; uses sld_pkg.
//
// Input channel: one received byte per transaction on i_byte_in with
// i_in_valid / o_in_ready. The block hunts for the two sync bytes, reads a
// big-endian 16-bit length, then streams the payload bytes out.
// Output channel: one result per transaction with o_out_valid / i_out_ready:
// a payload byte (last one flagged), a sync byte error or a length error.
// Header bytes that match produce no result.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_index
// (0 first sync byte, 1 second sync byte, 2 maximum length); idle only.
// Throughput is one byte per cycle while o_in_ready is high, set by the header
// and payload state machine in the front end. A result is written into the
// queue when its byte is accepted and then moves into the output register.
// When the receiver stalls, results collect in a two-entry queue behind the
// output register; o_in_ready drops once that queue is full.
// Reset is synchronous and active low: it empties the queue and output
// register, restarts the sync hunt and restores the register defaults.
`default_nettype none

module sync_length_stream_deframer
    import sld_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_byte_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_event_kind,
    output logic [7:0]         o_data_byte,
    output logic               o_last_of_frame,
    output logic [15:0]        o_frame_length
);

    logic    w_accept;
    t_result w_front_result;
    logic    w_front_valid;
    t_result w_queue_data;
    logic    w_queue_valid;
    logic    w_queue_full;
    logic    w_pop;
    t_result w_out_result;

    assign o_in_ready = !w_queue_full;
    assign w_accept   = i_in_valid && o_in_ready;

    sld_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_byte         (i_byte_in),
        .o_result       (w_front_result),
        .o_result_valid (w_front_valid)
    );

    sld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_result),
        .i_pop   (w_pop),
        .o_data  (w_queue_data),
        .o_valid (w_queue_valid),
        .o_full  (w_queue_full)
    );

    sld_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (w_queue_data),
        .i_valid  (w_queue_valid),
        .o_pop    (w_pop),
        .o_result (w_out_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready)
    );

    assign o_event_kind    = w_out_result.kind;
    assign o_data_byte     = w_out_result.data;
    assign o_last_of_frame = w_out_result.last;
    assign o_frame_length  = w_out_result.flen;

endmodule

`default_nettype wire
